// File: rtl/mm3_pkg.sv
// Shared types and constants for the MurmurHash3 x86_32 streaming hash engine.
// Used by mm3_ctrl, mm3_datapath and murmur3_x86_32_hash; no dependencies.
`default_nettype none

package mm3_pkg;

    // Mixing constants of the block and finalizer rules
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] N  = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    // Byte counts of a word
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL2,
        ST_MIX,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul2;
        logic mix;
        logic fin1;
        logic fin2;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/mm3_datapath.sv
// Datapath of the MurmurHash3 engine: key-word scramble, hash update, finalizer
// and the output register. Depends on mm3_pkg for constants and command types.
`default_nettype none

module mm3_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mm3_pkg::t_cmd   i_cmd,
    output mm3_pkg::t_status     o_status,
    input  wire logic [31:0]     i_block_word,
    input  wire logic [2:0]      i_byte_count,
    input  wire logic            i_first_item,
    input  wire logic            i_last_item,
    input  wire logic [30:0]     i_key_length,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [31:0]          o_hash_value
);

    logic [31:0] r_hash;
    logic [30:0] r_len;
    logic [31:0] r_k;
    logic [31:0] r_f;
    logic        r_full;
    logic        r_last;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic [31:0] n_masked;
    logic [31:0] n_k1;
    logic [31:0] n_rot15;
    logic [31:0] n_k2;
    logic [31:0] n_hx;
    logic [31:0] n_rot13;
    logic [31:0] n_hash;
    logic [31:0] n_f0;
    logic [31:0] n_fseed;
    logic [31:0] n_f1;
    logic [31:0] n_fx13;
    logic [31:0] n_f2;
    logic [31:0] n_out;

    // Keep only the valid bytes; counts above four act as a full word
    always_comb begin
        unique case (i_byte_count)
            3'd0:                n_masked = 32'd0;
            mm3_pkg::CNT_ONE:    n_masked = {24'd0, i_block_word[7:0]};
            mm3_pkg::CNT_TWO:    n_masked = {16'd0, i_block_word[15:0]};
            mm3_pkg::CNT_THREE:  n_masked = {8'd0, i_block_word[23:0]};
            default:             n_masked = i_block_word;
        endcase
    end

    // First multiply straight off the input port
    assign n_k1    = n_masked * mm3_pkg::C1;
    // rotl 15, then second multiply
    assign n_rot15 = {r_k[16:0], r_k[31:17]};
    assign n_k2    = n_rot15 * mm3_pkg::C2;

    // Hash update: xor in, and for a full block rotl 13 and h*5 + n
    assign n_hx    = r_hash ^ r_k;
    assign n_rot13 = {n_hx[18:0], n_hx[31:19]};
    assign n_hash  = r_full ? (n_rot13 + {n_rot13[29:0], 2'b00} + mm3_pkg::N) : n_hx;

    // Finalizer steps
    assign n_f0    = n_hash ^ {1'b0, r_len};
    assign n_fseed = n_f0 ^ {16'd0, n_f0[31:16]};
    assign n_f1    = r_f * mm3_pkg::F1;
    assign n_fx13  = r_f ^ {13'd0, r_f[31:13]};
    assign n_f2    = n_fx13 * mm3_pkg::F2;
    assign n_out   = r_f ^ {16'd0, r_f[31:16]};

    // Architectural state: running hash and saved length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= 32'd0;
            r_len  <= 31'd0;
        end else begin
            if (i_cmd.load && i_first_item) begin
                r_hash <= {1'b0, i_key_length};
                r_len  <= i_key_length;
            end else if (i_cmd.mix) begin
                r_hash <= n_hash;
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k    <= n_k1;
            r_full <= i_byte_count[2];
            r_last <= i_last_item;
        end else if (i_cmd.mul2) begin
            r_k <= n_k2;
        end
        if (i_cmd.mix) begin
            r_f <= n_fseed;
        end else if (i_cmd.fin1) begin
            r_f <= n_f1;
        end else if (i_cmd.fin2) begin
            r_f <= n_f2;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    // Output request flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_hash_value      = r_out;

endmodule

`default_nettype wire

// File: rtl/mm3_ctrl.sv
// Controller state machine of the MurmurHash3 engine: sequences load, mix and
// finalize commands for mm3_datapath. Depends on mm3_pkg for state and command types.
`default_nettype none

module mm3_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire mm3_pkg::t_status   i_status,
    output mm3_pkg::t_cmd           o_cmd
);

    mm3_pkg::t_state r_state;
    mm3_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mm3_pkg::ST_IDLE: begin
                if (i_valid) n_state = mm3_pkg::ST_MUL2;
            end
            mm3_pkg::ST_MUL2: n_state = mm3_pkg::ST_MIX;
            mm3_pkg::ST_MIX: begin
                n_state = i_status.last ? mm3_pkg::ST_FIN1 : mm3_pkg::ST_IDLE;
            end
            mm3_pkg::ST_FIN1: n_state = mm3_pkg::ST_FIN2;
            mm3_pkg::ST_FIN2: n_state = mm3_pkg::ST_FIN3;
            mm3_pkg::ST_FIN3: begin
                if (i_status.out_free) n_state = mm3_pkg::ST_IDLE;
            end
            default: n_state = mm3_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            mm3_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            mm3_pkg::ST_MUL2: o_cmd.mul2 = 1'b1;
            mm3_pkg::ST_MIX:  o_cmd.mix  = 1'b1;
            mm3_pkg::ST_FIN1: o_cmd.fin1 = 1'b1;
            mm3_pkg::ST_FIN2: o_cmd.fin2 = 1'b1;
            mm3_pkg::ST_FIN3: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/murmur3_x86_32_hash.sv
// MurmurHash3 x86_32 streaming hash engine, top level.
// Instantiates mm3_ctrl and mm3_datapath; depends on mm3_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one key word per request with its
//   byte count, first/last marks and, on the first word, the key length.
//   Output channel (o_valid / i_ready) gives one hash per key, on the request
//   that carried the last mark.
// Pacing: a word passes through accept, second scramble multiply and hash
//   update before the next is taken; the chain of two dependent constant
//   multiplies sets this. The hash reaches the output register after the last
//   word's hash update and the finalizer steps FIN1, FIN2 and FIN3, and no
//   next word is taken until FIN3 has loaded the output register.
// Stall: the output register holds the hash until taken; the engine keeps
//   accepting non-last words meanwhile, and a following last word waits in
//   its final step until the register is free.
// Reset: synchronous, active low; clears controller state, running hash, saved
//   length and the output request.
`default_nettype none

module murmur3_x86_32_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_block_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_first_item,
    input  wire logic        i_last_item,
    input  wire logic [30:0] i_key_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value
);

    mm3_pkg::t_cmd    cmd;
    mm3_pkg::t_status status;

    mm3_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mm3_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_block_word (i_block_word),
        .i_byte_count (i_byte_count),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_key_length (i_key_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

`ifndef NO_ASSERTIONS
    // One word at a time: ready drops right after a request is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a word is in flight");

    // A load command only ever comes with an accepted request
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_valid && o_ready))
        else $error("datapath loaded without an accepted request");

    // The output register is never overwritten while a hash waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("pending hash overwritten");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for murmur3_x86_32_hash: random and directed keys, hashes
// predicted in a scoreboard class. Depends on mm3_pkg and the RTL of the hash engine.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CNT_NONE     = 3'd0;
    localparam logic [2:0] CNT_FULL     = 3'd4;
    localparam int         RANDOM_REQS  = 900;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         CYCLE_LIMIT  = 300000;

    // Predicts MurmurHash3 x86_32 per key and checks hashes in order
    class hash_scoreboard;
        logic [31:0] running_hash;
        logic [30:0] saved_length;
        logic [31:0] expected_hashes[$];
        int          errors;
        int          hashes_checked;

        function new();
            running_hash   = '0;
            saved_length   = '0;
            errors         = 0;
            hashes_checked = 0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int r);
            return (x << r) | (x >> (32 - r));
        endfunction

        function logic [31:0] scramble(logic [31:0] k);
            k = k * mm3_pkg::C1;
            k = rotl(k, 15);
            k = k * mm3_pkg::C2;
            return k;
        endfunction

        function logic [31:0] fmix(logic [31:0] h);
            h = h ^ (h >> 16);
            h = h * mm3_pkg::F1;
            h = h ^ (h >> 13);
            h = h * mm3_pkg::F2;
            h = h ^ (h >> 16);
            return h;
        endfunction

        // Fold one accepted request into the running hash
        function void absorb_word(logic [31:0] word, logic [2:0] cnt, logic first,
                                  logic last, logic [30:0] len);
            logic [31:0] h;
            logic [31:0] mask;
            if (first) begin
                running_hash = {1'b0, len};
                saved_length = len;
            end
            h = running_hash;
            if (cnt >= CNT_FULL) begin
                h = h ^ scramble(word);
                h = rotl(h, 13);
                h = h * 32'd5 + mm3_pkg::N;
            end else if (cnt != CNT_NONE) begin
                // tail bytes: upper bytes are masked off
                mask = (32'd1 << (8 * cnt)) - 32'd1;
                h = h ^ scramble(word & mask);
            end
            running_hash = h;
            if (last)
                expected_hashes.push_back(fmix(h ^ {1'b0, saved_length}));
        endfunction

        function void check_hash(logic [31:0] got);
            logic [31:0] want;
            if (expected_hashes.size() == 0) begin
                $display("%0t: hash %08h arrived, expected none", $time, got);
                errors++;
            end else begin
                want = expected_hashes.pop_front();
                hashes_checked++;
                if (got !== want) begin
                    $display("%0t: hash mismatch: expected %08h, actual %08h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return expected_hashes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_block_word;
    logic [2:0]  i_byte_count;
    logic        i_first_item;
    logic        i_last_item;
    logic [30:0] i_key_length;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_hash_value;

    hash_scoreboard sb;
    int requests_sent = 0;
    int burst_left    = 0;
    int cycles        = 0;
    int rx_phase      = 0;
    int rx_period     = 1;
    int rx_duty       = 1;

    murmur3_x86_32_hash uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_word (i_block_word),
        .i_byte_count (i_byte_count),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_key_length (i_key_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_hash(o_hash_value);
            if (i_valid && o_ready)
                sb.absorb_word(i_block_word, i_byte_count, i_first_item, i_last_item,
                               i_key_length);
        end
    end

    // Receiver stall pattern: duty cycle over a short period, re-picked now and then
    always @(negedge i_clk) begin
        if (rx_phase + 1 >= rx_period) begin
            rx_phase = 0;
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    rx_period = 1;
                    rx_duty   = 1;
                end else begin
                    rx_period = $urandom_range(1, 8);
                    rx_duty   = $urandom_range(0, rx_period);
                end
            end
        end else begin
            rx_phase++;
        end
        i_ready <= (rx_phase < rx_duty);
    end

    // Present one request, hold it until taken, then maybe leave a gap
    task automatic send_req(input logic [31:0] word, input logic [2:0] cnt,
                            input logic first, input logic last, input logic [30:0] len);
        int gap;
        i_valid      <= 1'b1;
        i_block_word <= word;
        i_byte_count <= cnt;
        i_first_item <= first;
        i_last_item  <= last;
        i_key_length <= len;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Hold off new requests until every pending hash has come out
    task automatic wait_for_hashes();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Whole key of random bytes; optionally ended by a bare zero-count request
    task automatic send_key(input int nbytes, input logic [30:0] len, input bit bare_end);
        int nfull;
        int tail;
        nfull = nbytes / 4;
        tail  = nbytes % 4;
        if (nbytes == 0) begin
            send_req($urandom, CNT_NONE, 1'b1, 1'b1, len);
            return;
        end
        for (int i = 0; i < nfull; i++)
            send_req($urandom, CNT_FULL, i == 0,
                     (i == nfull - 1) && (tail == 0) && !bare_end,
                     (i == 0) ? len : 31'($urandom));
        if (tail != 0)
            send_req($urandom, 3'(tail), nfull == 0, 1'b1,
                     (nfull == 0) ? len : 31'($urandom));
        else if (bare_end)
            send_req($urandom, CNT_NONE, 1'b0, 1'b1, 31'($urandom));
    endtask

    initial begin
        int start;
        int kind;
        int nbytes;
        int nreq;
        sb           = new();
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_block_word = '0;
        i_byte_count = CNT_NONE;
        i_first_item = 1'b0;
        i_last_item  = 1'b0;
        i_key_length = '0;
        i_ready      = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // requests before any key start run on the reset state
        send_req(32'hffffffff, CNT_FULL, 1'b0, 1'b0, 31'h7fffffff);
        send_req(32'h12345678, CNT_NONE, 1'b0, 1'b1, 31'd0);
        // empty key
        send_req(32'hffffffff, CNT_NONE, 1'b1, 1'b1, 31'd0);
        // single-request keys of one to four bytes, garbage above the count
        send_req(32'hffffffff, mm3_pkg::CNT_ONE, 1'b1, 1'b1, 31'd1);
        send_req(32'hffffffff, mm3_pkg::CNT_TWO, 1'b1, 1'b1, 31'd2);
        send_req(32'hffffffff, mm3_pkg::CNT_THREE, 1'b1, 1'b1, 31'd3);
        send_req(32'hffffffff, CNT_FULL, 1'b1, 1'b1, 31'd4);
        // eight bytes ending on a full word
        send_req(32'h00000000, CNT_FULL, 1'b1, 1'b0, 31'd8);
        send_req(32'hffffffff, CNT_FULL, 1'b0, 1'b1, 31'd0);
        // block then a three-byte tail
        send_req(32'h64636261, CNT_FULL, 1'b1, 1'b0, 31'd7);
        send_req(32'hff676665, mm3_pkg::CNT_THREE, 1'b0, 1'b1, 31'd0);
        // counts above four mix as a full block
        send_req(32'h80000001, 3'd5, 1'b1, 1'b1, 31'h7fffffff);
        send_req(32'h7ffffffe, 3'd6, 1'b1, 1'b1, 31'h7fffffff);
        send_req(32'hffffffff, 3'd7, 1'b1, 1'b1, 31'h7fffffff);
        // short word mid-stream, then a block, then a bare end mark
        send_req(32'hdeadbeef, mm3_pkg::CNT_TWO, 1'b1, 1'b0, 31'd6);
        send_req(32'hcafef00d, CNT_FULL, 1'b0, 1'b0, 31'd0);
        send_req(32'h00000000, CNT_NONE, 1'b0, 1'b1, 31'd0);
        // stated length disagrees with the bytes sent
        send_req(32'h5a5a5a5a, CNT_FULL, 1'b1, 1'b1, 31'h55555555);
        send_req(32'ha5a5a5a5, mm3_pkg::CNT_ONE, 1'b1, 1'b1, 31'h2aaaaaaa);
        wait_for_hashes();

        // random part: mostly well-formed keys, some odd lengths and broken streams
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQS) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                     : $urandom_range(0, 24);
                send_key(nbytes, 31'(nbytes), 1'($urandom_range(0, 1)));
            end else if (kind < 88) begin
                nbytes = $urandom_range(0, 24);
                send_key(nbytes, 31'($urandom), 1'($urandom_range(0, 1)));
            end else if (kind < 95) begin
                nreq = $urandom_range(1, 5);
                for (int i = 0; i < nreq; i++)
                    send_req($urandom, 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)),
                             (i == nreq - 1) ? 1'($urandom_range(0, 1))
                                             : 1'($urandom_range(0, 3) == 0),
                             31'($urandom));
            end else if (kind < 99) begin
                send_req($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 31'($urandom));
            end else begin
                wait_for_hashes();
            end
        end

        wait_for_hashes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests sent, %0d hashes checked, %0d mismatches",
                 requests_sent, sb.hashes_checked, sb.errors);
        $display("tb: covered empty keys, tails, oversize counts, bare ends, bad lengths");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
